>>> hw/rtl/bpdc_pkg.sv
// Shared types, codes and helpers for the button press duration classifier.
package bpdc_pkg;

	// Event codes carried in event_code
	localparam logic [2:0] EV_NONE    = 3'd0;
	localparam logic [2:0] EV_PRESSED = 3'd1;
	localparam logic [2:0] EV_SHORT   = 3'd2;
	localparam logic [2:0] EV_DFU     = 3'd3;
	localparam logic [2:0] EV_RESET   = 3'd4;

	// Configuration register indexes
	localparam int unsigned CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DFU_HOLD   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_RESET_HOLD = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_EDGE_EN    = 2'd3;

	localparam int unsigned CFG_DATA_W = 16;

	// Reset values of the configuration registers
	localparam logic [15:0] DEBOUNCE_RST   = 16'd50;
	localparam logic [15:0] DFU_HOLD_RST   = 16'd3000;
	localparam logic [15:0] RESET_HOLD_RST = 16'd10000;
	localparam logic        EDGE_EN_RST    = 1'b1;

	typedef struct packed {
		logic        level_pressed;
		logic        edge_pending;
		logic [31:0] now_ms;
	} in_word_t;

	typedef struct packed {
		logic [2:0]  event_code;
		logic        is_pressed;
		logic [15:0] press_total;
		logic [15:0] hold_total;
	} out_word_t;

	typedef struct packed {
		logic [15:0] debounce_ms;
		logic [15:0] dfu_hold_ms;
		logic [15:0] reset_hold_ms;
		logic        edge_enable;
	} cfg_t;

	typedef struct packed {
		logic        prior_level;
		logic        held_flag;
		logic [31:0] press_start;
		logic [2:0]  prior_event;
		logic [15:0] press_counter;
		logic [15:0] hold_counter;
	} state_t;

	// Hold event for a held button: reset, else DFU, skipping whichever would repeat the last event
	function automatic logic [2:0] hold_event(
		input logic       ge_reset,
		input logic       ge_dfu,
		input logic [2:0] last
	);
		logic [2:0] ev;
		ev = EV_NONE;
		if (ge_reset && (last != EV_RESET)) begin
			ev = EV_RESET;
		end else if (ge_dfu && (last != EV_DFU)) begin
			ev = EV_DFU;
		end
		return ev;
	endfunction

endpackage

>>> hw/rtl/button_press_duration_classifier_core.sv
// Button press duration classifier: top level with config, state and pipeline registers.
// A poll word is held in the input register, its result word then in the result register.
// Throughput: one poll word per cycle; the classifier state updates in a single pass.
// A waiting result stalls intake only once the input register is full as well.
// Reset: arst_n clears state, counters and valids; config returns to 50/3000/10000 ms, edges on.
module button_press_duration_classifier_core (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_stall,
	input  bpdc_pkg::in_word_t                    in_word,
	output logic                                  out_valid,
	input  logic                                  out_stall,
	output bpdc_pkg::out_word_t                   out_word,
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [bpdc_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [bpdc_pkg::CFG_DATA_W-1:0]       cfg_data
);

	bpdc_pkg::cfg_t      cfg_q;
	bpdc_pkg::state_t    state_q;
	bpdc_pkg::state_t    state_nxt;
	bpdc_pkg::in_word_t  word_s1;
	logic                valid_s1;
	bpdc_pkg::out_word_t word_s2;
	logic                valid_s2;
	bpdc_pkg::out_word_t res;
	logic                res_free;
	logic                advance;
	logic                take_in;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.debounce_ms   <= bpdc_pkg::DEBOUNCE_RST;
			cfg_q.dfu_hold_ms   <= bpdc_pkg::DFU_HOLD_RST;
			cfg_q.reset_hold_ms <= bpdc_pkg::RESET_HOLD_RST;
			cfg_q.edge_enable   <= bpdc_pkg::EDGE_EN_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				bpdc_pkg::REG_DEBOUNCE:   cfg_q.debounce_ms   <= cfg_data;
				bpdc_pkg::REG_DFU_HOLD:   cfg_q.dfu_hold_ms   <= cfg_data;
				bpdc_pkg::REG_RESET_HOLD: cfg_q.reset_hold_ms <= cfg_data;
				bpdc_pkg::REG_EDGE_EN:    cfg_q.edge_enable   <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Result register frees when empty or when its word is taken this cycle
	assign res_free = !valid_s2 || !out_stall;
	assign advance  = valid_s1 && res_free;
	assign in_stall = valid_s1 && !res_free;
	assign take_in  = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take_in || advance) begin
			valid_s1 <= take_in;
		end
	end

	always_ff @(posedge clk) begin
		if (take_in) begin
			word_s1 <= in_word;
		end
	end

	bpdc_step u_step (
		.cfg  (cfg_q),
		.cur  (state_q),
		.word (word_s1),
		.nxt  (state_nxt),
		.res  (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (advance) begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (res_free) begin
			valid_s2 <= advance;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			word_s2 <= res;
		end
	end

	assign out_valid = valid_s2;
	assign out_word  = word_s2;

endmodule

>>> hw/rtl/bpdc_step.sv
// Next-state and result logic for one poll word.
module bpdc_step (
	input  bpdc_pkg::cfg_t      cfg,
	input  bpdc_pkg::state_t    cur,
	input  bpdc_pkg::in_word_t  word,
	output bpdc_pkg::state_t    nxt,
	output bpdc_pkg::out_word_t res
);

	logic        handled;
	logic        rise;
	logic        fall;
	logic        held_n;
	logic [31:0] start_n;
	logic [31:0] dur;
	logic        ge_reset;
	logic        ge_dfu;
	logic        ge_deb;
	logic [2:0]  ev_edge;
	logic [2:0] hold1;
	logic [2:0] ev_after;
	logic [2:0] prior_ev1;
	logic [2:0] hold2;
	logic [2:0] ev_final;
	logic [2:0] prior_ev_n;

	assign handled = word.edge_pending & cfg.edge_enable;
	assign rise    = handled & word.level_pressed & ~cur.prior_level;
	assign fall    = handled & ~word.level_pressed & cur.prior_level;

	assign start_n = rise ? word.now_ms : cur.press_start;
	assign held_n  = rise ? 1'b1 : (fall ? 1'b0 : cur.held_flag);

	// On a release start_n is still the old start, so one subtract serves all checks
	assign dur      = word.now_ms - start_n;
	assign ge_reset = dur >= {16'd0, cfg.reset_hold_ms};
	assign ge_dfu   = dur >= {16'd0, cfg.dfu_hold_ms};
	assign ge_deb   = dur >= {16'd0, cfg.debounce_ms};

	always_comb begin
		ev_edge = bpdc_pkg::EV_NONE;
		if (rise) begin
			ev_edge = bpdc_pkg::EV_PRESSED;
		end else if (fall) begin
			priority if (ge_reset) begin
				ev_edge = bpdc_pkg::EV_RESET;
			end else if (ge_dfu) begin
				ev_edge = bpdc_pkg::EV_DFU;
			end else if (ge_deb) begin
				ev_edge = bpdc_pkg::EV_SHORT;
			end else begin
				ev_edge = bpdc_pkg::EV_NONE;
			end
		end
	end

	// Hold check inside edge handling, only while the level reads pressed
	assign hold1    = (held_n & word.level_pressed)
		? bpdc_pkg::hold_event(ge_reset, ge_dfu, cur.prior_event) : bpdc_pkg::EV_NONE;
	assign ev_after = (hold1 != bpdc_pkg::EV_NONE) ? hold1 : ev_edge;
	assign prior_ev1 = handled ? ev_after : cur.prior_event;

	// Hold check on every poll; may alternate reset and DFU hold
	assign hold2 = held_n
		? bpdc_pkg::hold_event(ge_reset, ge_dfu, prior_ev1) : bpdc_pkg::EV_NONE;

	always_comb begin
		if (hold2 != bpdc_pkg::EV_NONE) begin
			ev_final   = hold2;
			prior_ev_n = hold2;
		end else begin
			ev_final   = handled ? ev_after : bpdc_pkg::EV_NONE;
			prior_ev_n = prior_ev1;
		end
	end

	always_comb begin
		nxt.prior_level   = handled ? word.level_pressed : cur.prior_level;
		nxt.held_flag     = held_n;
		nxt.press_start   = start_n;
		nxt.prior_event   = prior_ev_n;
		nxt.press_counter = cur.press_counter + {15'd0, rise};
		nxt.hold_counter  = cur.hold_counter + {15'd0, fall & (ge_reset | ge_dfu)};
	end

	always_comb begin
		res.event_code  = ev_final;
		res.is_pressed  = held_n;
		res.press_total = nxt.press_counter;
		res.hold_total  = nxt.hold_counter;
	end

endmodule
